/* rtl/dod_pkg.sv */
package dod_pkg;

    // Field widths of the streams and registers.
    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int PAD_W   = 12;
    localparam int SCALE_W = 24;
    localparam int PIX_W   = 13;
    localparam int NCLS_W  = 9;
    localparam int CLASS_W = 8;

    // Configuration port shape.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Edge magnitude in 1/32 model pixels, and scaled values in original pixels.
    localparam int MAG_W    = 17;
    localparam int SCALED_W = 20;

    // Highest number of classes the argmax ever looks at.
    localparam int MAX_CLASSES = 256;
    localparam logic [NCLS_W-1:0] CLASS_LIMIT =
        NCLS_W'((MAX_CLASSES < 256) ? MAX_CLASSES : 256);
    localparam logic [NCLS_W-1:0] INDEX_MAX = '1;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_PAD_X           = 3'd1,
        REG_PAD_Y           = 3'd2,
        REG_SCALE_X         = 3'd3,
        REG_SCALE_Y         = 3'd4,
        REG_IMAGE_WIDTH     = 3'd5,
        REG_IMAGE_HEIGHT    = 3'd6,
        REG_NUM_CLASSES     = 3'd7
    } cfg_index_t;

    // Item kinds on the input stream.
    typedef enum logic {
        KIND_BOX   = 1'b0,
        KIND_SCORE = 1'b1
    } kind_t;

    // Register reset values.
    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd16384;
    localparam logic [PAD_W-1:0]   RST_PAD             = 12'd0;
    localparam logic [SCALE_W-1:0] RST_SCALE           = 24'd65536;
    localparam logic [PIX_W-1:0]   RST_IMAGE_SIZE      = 13'd640;
    localparam logic [NCLS_W-1:0]  RST_NUM_CLASSES     = 9'd80;

    typedef struct packed {
        logic [SCORE_W-1:0] score_threshold;
        logic [PAD_W-1:0]   pad_x;
        logic [PAD_W-1:0]   pad_y;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
        logic [PIX_W-1:0]   image_width;
        logic [PIX_W-1:0]   image_height;
        logic [NCLS_W-1:0]  num_classes;
    } cfg_t;

    // A detection that passed the threshold, waiting for box scaling.
    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0] confidence;
        logic [MAG_W-1:0]   x_mag;
        logic [MAG_W-1:0]   y_mag;
        logic [COORD_W-1:0] box_w;
        logic [COORD_W-1:0] box_h;
    } cand_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0] confidence;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   width;
        logic [PIX_W-1:0]   height;
    } res_t;

endpackage

/* rtl/dod_if.sv */
interface dod_in_if
    import dod_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] box_w;
    logic [COORD_W-1:0] box_h;
    logic [SCORE_W-1:0] class_score;
    logic               last_score;

    modport source (
        output valid, kind, center_x, center_y, box_w, box_h, class_score, last_score,
        input  ready
    );
    modport sink (
        input  valid, kind, center_x, center_y, box_w, box_h, class_score, last_score,
        output ready
    );
endinterface

interface dod_out_if
    import dod_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] class_id;
    logic [SCORE_W-1:0] confidence;
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   width;
    logic [PIX_W-1:0]   height;

    modport source (
        output valid, class_id, confidence, left, top, width, height,
        input  ready
    );
    modport sink (
        input  valid, class_id, confidence, left, top, width, height,
        output ready
    );
endinterface

/* rtl/dod_cfg_regs.sv */
module dod_cfg_regs
    import dod_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and replace the addressed field.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SCORE_THRESHOLD: cfg_next.score_threshold = cfg_data[SCORE_W-1:0];
                REG_PAD_X:           cfg_next.pad_x           = cfg_data[PAD_W-1:0];
                REG_PAD_Y:           cfg_next.pad_y           = cfg_data[PAD_W-1:0];
                REG_SCALE_X:         cfg_next.scale_x         = cfg_data[SCALE_W-1:0];
                REG_SCALE_Y:         cfg_next.scale_y         = cfg_data[SCALE_W-1:0];
                REG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[PIX_W-1:0];
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_data[PIX_W-1:0];
                REG_NUM_CLASSES:     cfg_next.num_classes     = cfg_data[NCLS_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.score_threshold <= RST_SCORE_THRESHOLD;
            cfg_reg.pad_x           <= RST_PAD;
            cfg_reg.pad_y           <= RST_PAD;
            cfg_reg.scale_x         <= RST_SCALE;
            cfg_reg.scale_y         <= RST_SCALE;
            cfg_reg.image_width     <= RST_IMAGE_SIZE;
            cfg_reg.image_height    <= RST_IMAGE_SIZE;
            cfg_reg.num_classes     <= RST_NUM_CLASSES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/dod_argmax.sv */
module dod_argmax
    import dod_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    dod_in_if.sink       det_in,
    output logic         cand_valid,
    output cand_t        cand,
    input  logic         cand_ready
);

    logic [COORD_W-1:0] held_cx_reg, held_cy_reg, held_w_reg, held_h_reg;
    logic [COORD_W-1:0] held_cx_next, held_cy_next, held_w_next, held_h_next;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [CLASS_W-1:0] best_class_reg, best_class_next;
    logic [NCLS_W-1:0]  class_index_reg, class_index_next;
    logic               cand_valid_reg, cand_valid_next;
    cand_t              cand_reg, cand_next;

    logic               xfer;
    logic               counted;
    logic [SCORE_W-1:0] score_upd;
    logic [CLASS_W-1:0] class_upd;
    logic               emit;

    // Left or top edge in 1/32 model pixels: 2*center - size - 32*pad, floored at zero.
    function automatic logic [MAG_W-1:0] edge_mag(
        input logic [COORD_W-1:0] c,
        input logic [COORD_W-1:0] sz,
        input logic [PAD_W-1:0]   pad
    );
        logic signed [MAG_W+1:0] v;
        v = $signed({2'b00, c, 1'b0}) - $signed({3'b000, sz})
            - $signed({2'b00, pad, 5'b00000});
        edge_mag = (v > 0) ? v[MAG_W-1:0] : '0;
    endfunction

    // The input register is free when the candidate stage is empty or drains.
    assign det_in.ready = !cand_valid_reg || cand_ready;
    assign xfer         = det_in.valid && det_in.ready;

    // Running strict-greater argmax over the scores that count.
    always_comb
    begin
        counted   = (class_index_reg < cfg.num_classes) && (class_index_reg < CLASS_LIMIT);
        score_upd = best_score_reg;
        class_upd = best_class_reg;
        if (counted && (det_in.class_score > best_score_reg))
        begin
            score_upd = det_in.class_score;
            class_upd = class_index_reg[CLASS_W-1:0];
        end
        emit = (det_in.kind == KIND_SCORE) && det_in.last_score
               && (score_upd >= cfg.score_threshold);
    end

    // Detection state updates on each transfer.
    always_comb
    begin
        held_cx_next     = held_cx_reg;
        held_cy_next     = held_cy_reg;
        held_w_next      = held_w_reg;
        held_h_next      = held_h_reg;
        best_score_next  = best_score_reg;
        best_class_next  = best_class_reg;
        class_index_next = class_index_reg;
        if (xfer)
        begin
            if (det_in.kind == KIND_BOX)
            begin
                held_cx_next     = det_in.center_x;
                held_cy_next     = det_in.center_y;
                held_w_next      = det_in.box_w;
                held_h_next      = det_in.box_h;
                best_score_next  = '0;
                best_class_next  = '0;
                class_index_next = '0;
            end
            else
            begin
                best_score_next = score_upd;
                best_class_next = class_upd;
                if (class_index_reg != INDEX_MAX)
                begin
                    class_index_next = class_index_reg + NCLS_W'(1);
                end
            end
        end
    end

    // Candidate stage: holds a reportable detection until box scaling takes it.
    always_comb
    begin
        cand_valid_next = cand_valid_reg && !cand_ready;
        cand_next       = cand_reg;
        if (xfer)
        begin
            cand_valid_next = emit;
        end
        if (xfer && emit)
        begin
            cand_next.class_id   = class_upd;
            cand_next.confidence = score_upd;
            cand_next.x_mag      = edge_mag(held_cx_reg, held_w_reg, cfg.pad_x);
            cand_next.y_mag      = edge_mag(held_cy_reg, held_h_reg, cfg.pad_y);
            cand_next.box_w      = held_w_reg;
            cand_next.box_h      = held_h_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cx_reg     <= '0;
            held_cy_reg     <= '0;
            held_w_reg      <= '0;
            held_h_reg      <= '0;
            best_score_reg  <= '0;
            best_class_reg  <= '0;
            class_index_reg <= '0;
            cand_valid_reg  <= 1'b0;
        end
        else
        begin
            held_cx_reg     <= held_cx_next;
            held_cy_reg     <= held_cy_next;
            held_w_reg      <= held_w_next;
            held_h_reg      <= held_h_next;
            best_score_reg  <= best_score_next;
            best_class_reg  <= best_class_next;
            class_index_reg <= class_index_next;
            cand_valid_reg  <= cand_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_valid = cand_valid_reg;
    assign cand       = cand_reg;

    // A box transfer restarts the argmax.
    a_box_clears: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && (det_in.kind == KIND_BOX)
        |=> (best_score_reg == '0) && (best_class_reg == '0) && (class_index_reg == '0))
        else $error("argmax state not cleared by a box transfer");

    // Each score transfer advances the class index until it saturates.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && (det_in.kind == KIND_SCORE) && (class_index_reg != INDEX_MAX)
        |=> class_index_reg == $past(class_index_reg) + NCLS_W'(1))
        else $error("class index did not advance on a score transfer");

    // The best score never drops except through a box transfer.
    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(xfer && (det_in.kind == KIND_BOX)) |=> best_score_reg >= $past(best_score_reg))
        else $error("best score dropped without a box transfer");

endmodule

/* rtl/dod_box_scale.sv */
module dod_box_scale
    import dod_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  cand_valid,
    input  cand_t cand,
    output logic  cand_ready,
    output logic  res_valid,
    output res_t  res,
    input  logic  res_ready
);

    localparam int PROD_EDGE_W = MAG_W + SCALE_W;
    localparam int PROD_SIZE_W = COORD_W + SCALE_W;
    localparam int ROOM_W      = SCALED_W + 1;

    logic                en2, en3;
    logic                s2_valid_reg, s2_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [CLASS_W-1:0]  s2_class_reg;
    logic [SCORE_W-1:0]  s2_conf_reg;
    logic [SCALED_W-1:0] s2_left_reg, s2_top_reg, s2_rw_reg, s2_rh_reg;
    res_t                res_reg;

    logic [PROD_EDGE_W-1:0] left_prod, top_prod;
    logic [PROD_SIZE_W-1:0] rw_prod, rh_prod;

    logic signed [ROOM_W-1:0] room_x, room_y, raw_w, raw_h, w_clamped, h_clamped;
    logic                     pass;

    // Stage enables: each stage moves when the one after it can take data.
    assign en3        = !out_valid_reg || res_ready;
    assign en2        = !s2_valid_reg || en3;
    assign cand_ready = en2;

    // Scale stage: one multiplier per edge and per size.
    assign left_prod = PROD_EDGE_W'(cand.x_mag) * PROD_EDGE_W'(cfg.scale_x);
    assign top_prod  = PROD_EDGE_W'(cand.y_mag) * PROD_EDGE_W'(cfg.scale_y);
    assign rw_prod   = PROD_SIZE_W'(cand.box_w) * PROD_SIZE_W'(cfg.scale_x);
    assign rh_prod   = PROD_SIZE_W'(cand.box_h) * PROD_SIZE_W'(cfg.scale_y);

    // Clamp stage: limit the size to the room left before the image edge.
    always_comb
    begin
        room_x    = $signed({{(ROOM_W-PIX_W){1'b0}}, cfg.image_width})
                    - $signed({1'b0, s2_left_reg});
        room_y    = $signed({{(ROOM_W-PIX_W){1'b0}}, cfg.image_height})
                    - $signed({1'b0, s2_top_reg});
        raw_w     = $signed({1'b0, s2_rw_reg});
        raw_h     = $signed({1'b0, s2_rh_reg});
        w_clamped = (raw_w < room_x) ? raw_w : room_x;
        h_clamped = (raw_h < room_y) ? raw_h : room_y;
        pass      = (w_clamped > 0) && (h_clamped > 0);
    end

    always_comb
    begin
        s2_valid_next  = en2 ? cand_valid : s2_valid_reg;
        out_valid_next = en3 ? (s2_valid_reg && pass) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the scale stage.
    always_ff @(posedge clk)
    begin
        if (en2 && cand_valid)
        begin
            s2_class_reg <= cand.class_id;
            s2_conf_reg  <= cand.confidence;
            s2_left_reg  <= left_prod[PROD_EDGE_W-1 -: SCALED_W];
            s2_top_reg   <= top_prod[PROD_EDGE_W-1 -: SCALED_W];
            s2_rw_reg    <= rw_prod[PROD_SIZE_W-1 -: SCALED_W];
            s2_rh_reg    <= rh_prod[PROD_SIZE_W-1 -: SCALED_W];
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            res_reg.class_id   <= s2_class_reg;
            res_reg.confidence <= s2_conf_reg;
            res_reg.left       <= s2_left_reg[PIX_W-1:0];
            res_reg.top        <= s2_top_reg[PIX_W-1:0];
            res_reg.width      <= w_clamped[PIX_W-1:0];
            res_reg.height     <= h_clamped[PIX_W-1:0];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // A reported box always has a nonzero size.
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.width != '0) && (res.height != '0))
        else $error("result with zero width or height");

    // A stalled scale stage keeps its item.
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !en3 |=> s2_valid_reg)
        else $error("scale stage lost an item while stalled");

    // The scale stage fills only from a candidate transfer.
    a_s2_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_valid_reg ##1 s2_valid_reg |-> $past(cand_valid && cand_ready))
        else $error("scale stage filled without a candidate transfer");

endmodule

/* rtl/detection_output_decoder_core.sv */
// Detection output decoder. A box transfer (kind 0) latches a box and restarts
// the class argmax; each score transfer (kind 1) updates the argmax, and a score
// marked last_score yields one result when the best score reaches
// score_threshold and the scaled box has positive width and height. The block
// takes one item every cycle while the input is not stalled; the argmax register
// loop sets that rate. A result forms from the transfer of its last score: the
// candidate register loads at that transfer, the scale stage with the four
// multipliers follows, and the clamp feeds the result register. While a result
// waits to be taken the stages behind it hold and only fill their empty slots;
// the input stalls once the candidate stage holds a detection that cannot move on.
// Registers may be written only while no item is in flight.
module detection_output_decoder_core
    import dod_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dod_in_if.sink                det_in,
    dod_out_if.source             det_out
);

    cfg_t  cfg;
    logic  cand_valid;
    cand_t cand;
    logic  cand_ready;
    logic  res_valid;
    res_t  res;

    // Configuration registers.
    dod_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Argmax and candidate stage.
    dod_argmax u_argmax (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .det_in     (det_in),
        .cand_valid (cand_valid),
        .cand       (cand),
        .cand_ready (cand_ready)
    );

    // Box scaling, clamping and the result register.
    dod_box_scale u_box_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cand_valid (cand_valid),
        .cand       (cand),
        .cand_ready (cand_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (det_out.ready)
    );

    // Result channel.
    assign det_out.valid      = res_valid;
    assign det_out.class_id   = res.class_id;
    assign det_out.confidence = res.confidence;
    assign det_out.left       = res.left;
    assign det_out.top        = res.top;
    assign det_out.width      = res.width;
    assign det_out.height     = res.height;

endmodule

/* tb/tb_detection_output_decoder_core.sv */
import dod_pkg::*;

// One item on the detection input stream.
typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] box_w;
    logic [COORD_W-1:0] box_h;
    logic [SCORE_W-1:0] class_score;
    logic               last_score;
} det_item_t;

// Tracks the decoder state from the accepted input transfers and holds the
// detections that the output stream still owes.
class det_scoreboard;
    cfg_t               regs;
    logic [COORD_W-1:0] box_cx;
    logic [COORD_W-1:0] box_cy;
    logic [COORD_W-1:0] box_w;
    logic [COORD_W-1:0] box_h;
    logic [SCORE_W-1:0] top_score;
    logic [CLASS_W-1:0] top_class;
    logic [NCLS_W-1:0]  score_count;
    res_t               pending[$];
    int                 errors;
    int                 checked;

    function new();
        regs.score_threshold = RST_SCORE_THRESHOLD;
        regs.pad_x           = RST_PAD;
        regs.pad_y           = RST_PAD;
        regs.scale_x         = RST_SCALE;
        regs.scale_y         = RST_SCALE;
        regs.image_width     = RST_IMAGE_SIZE;
        regs.image_height    = RST_IMAGE_SIZE;
        regs.num_classes     = RST_NUM_CLASSES;
        box_cx      = '0;
        box_cy      = '0;
        box_w       = '0;
        box_h       = '0;
        top_score   = '0;
        top_class   = '0;
        score_count = '0;
        errors      = 0;
        checked     = 0;
    endfunction

    // Mirror of a register write on the configuration port.
    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SCORE_THRESHOLD: regs.score_threshold = data[SCORE_W-1:0];
            REG_PAD_X:           regs.pad_x           = data[PAD_W-1:0];
            REG_PAD_Y:           regs.pad_y           = data[PAD_W-1:0];
            REG_SCALE_X:         regs.scale_x         = data[SCALE_W-1:0];
            REG_SCALE_Y:         regs.scale_y         = data[SCALE_W-1:0];
            REG_IMAGE_WIDTH:     regs.image_width     = data[PIX_W-1:0];
            REG_IMAGE_HEIGHT:    regs.image_height    = data[PIX_W-1:0];
            REG_NUM_CLASSES:     regs.num_classes     = data[NCLS_W-1:0];
            default: ;
        endcase
    endfunction

    // Box edge in original pixels; the edge is worked out in 1/32 model pixels
    // and clamped at zero before scaling.
    function longint edge_px(logic [COORD_W-1:0] c, logic [COORD_W-1:0] sz,
                             logic [PAD_W-1:0] pad, logic [SCALE_W-1:0] scale);
        longint v;
        v = 2 * longint'(c) - longint'(sz) - 32 * longint'(pad);
        if (v <= 0)
            return 0;
        return (v * longint'(scale)) >>> 21;
    endfunction

    // Scaled box size, cut back to the room left before the image edge.
    function longint span(logic [COORD_W-1:0] sz, logic [SCALE_W-1:0] scale,
                          logic [PIX_W-1:0] bound, longint start);
        longint raw;
        longint room;
        raw  = (longint'(sz) * longint'(scale)) >>> 20;
        room = longint'(bound) - start;
        return (raw < room) ? raw : room;
    endfunction

    // Update the argmax and box for one accepted input transfer.
    function void note_input(det_item_t it);
        longint lim;
        longint left_px;
        longint top_px;
        longint w_px;
        longint h_px;
        res_t   det;
        if (it.kind == KIND_BOX)
        begin
            box_cx      = it.center_x;
            box_cy      = it.center_y;
            box_w       = it.box_w;
            box_h       = it.box_h;
            top_score   = '0;
            top_class   = '0;
            score_count = '0;
            return;
        end
        lim = longint'(regs.num_classes);
        if (lim > longint'(CLASS_LIMIT))
            lim = longint'(CLASS_LIMIT);
        if (longint'(score_count) < lim && it.class_score > top_score)
        begin
            top_score = it.class_score;
            top_class = score_count[CLASS_W-1:0];
        end
        if (score_count != INDEX_MAX)
            score_count++;
        if (!it.last_score || top_score < regs.score_threshold)
            return;
        left_px = edge_px(box_cx, box_w, regs.pad_x, regs.scale_x);
        top_px  = edge_px(box_cy, box_h, regs.pad_y, regs.scale_y);
        w_px    = span(box_w, regs.scale_x, regs.image_width, left_px);
        h_px    = span(box_h, regs.scale_y, regs.image_height, top_px);
        if (w_px <= 0 || h_px <= 0)
            return;
        det.class_id   = top_class;
        det.confidence = top_score;
        det.left       = left_px[PIX_W-1:0];
        det.top        = top_px[PIX_W-1:0];
        det.width      = w_px[PIX_W-1:0];
        det.height     = h_px[PIX_W-1:0];
        pending.insert(pending.size(), det);
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compare one output transfer with the oldest detection owed.
    task check_result(res_t got);
        res_t want;
        checked++;
        if (pending.size() == 0)
        begin
            report($sformatf("unexpected detection class %0d conf %h",
                             got.class_id, got.confidence));
            return;
        end
        want = pending.pop_front();
        if (got.class_id !== want.class_id)
            report($sformatf("class_id %0d, want %0d", got.class_id, want.class_id));
        if (got.confidence !== want.confidence)
            report($sformatf("confidence %h, want %h", got.confidence, want.confidence));
        if (got.left !== want.left)
            report($sformatf("left %0d, want %0d", got.left, want.left));
        if (got.top !== want.top)
            report($sformatf("top %0d, want %0d", got.top, want.top));
        if (got.width !== want.width)
            report($sformatf("width %0d, want %0d", got.width, want.width));
        if (got.height !== want.height)
            report($sformatf("height %0d, want %0d", got.height, want.height));
    endtask
endclass

module tb_detection_output_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1150;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_IDLE = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dod_in_if  det_in_bus ();
    dod_out_if det_out_bus ();

    det_scoreboard sb;
    bit            idle_on;
    bit            hold_req;
    int            items_sent;

    detection_output_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .det_in    (det_in_bus),
        .det_out   (det_out_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Fully random item; callers overwrite the fields that matter.
    function automatic det_item_t rand_item();
        det_item_t it;
        it.kind        = kind_t'($urandom_range(0, 1));
        it.center_x    = COORD_W'($urandom);
        it.center_y    = COORD_W'($urandom);
        it.box_w       = COORD_W'($urandom);
        it.box_h       = COORD_W'($urandom);
        it.class_score = SCORE_W'($urandom);
        it.last_score  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offer one item after a random gap and hold it until the transfer.
    task automatic send_item(det_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            det_in_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        det_in_bus.valid       <= 1'b1;
        det_in_bus.kind        <= it.kind;
        det_in_bus.center_x    <= it.center_x;
        det_in_bus.center_y    <= it.center_y;
        det_in_bus.box_w       <= it.box_w;
        det_in_bus.box_h       <= it.box_h;
        det_in_bus.class_score <= it.class_score;
        det_in_bus.last_score  <= it.last_score;
        do @(posedge clk); while (!det_in_bus.ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_box(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                            logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
        det_item_t it;
        it          = rand_item();
        it.kind     = KIND_BOX;
        it.center_x = cx;
        it.center_y = cy;
        it.box_w    = w;
        it.box_h    = h;
        send_item(it);
    endtask

    task automatic send_score(logic [SCORE_W-1:0] score, logic last);
        det_item_t it;
        it             = rand_item();
        it.kind        = KIND_SCORE;
        it.class_score = score;
        it.last_score  = last;
        send_item(it);
    endtask

    // A box followed by its class scores, the final one flagged last.
    task automatic send_detection(int n_scores, bit framed);
        logic [SCORE_W-1:0] score;
        if (framed)
            send_box(COORD_W'($urandom_range(0, 16'h2800)),
                     COORD_W'($urandom_range(0, 16'h2800)),
                     COORD_W'($urandom_range(1, 16'h1000)),
                     COORD_W'($urandom_range(1, 16'h1000)));
        else
            send_box(COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom));
        for (int i = 0; i < n_scores; i++)
        begin
            case ($urandom_range(0, 3))
                0:       score = 16'hFFFF;
                1:       score = SCORE_W'($urandom_range(0, 16'h00FF));
                default: score = SCORE_W'($urandom);
            endcase
            send_score(score, i == n_scores - 1);
        end
    endtask

    // Mostly well-formed detections, with stray items mixed in.
    task automatic run_random(int count);
        int target;
        int n;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 90)
                                                 : $urandom_range(1, 6);
                send_detection(n, 1'($urandom_range(0, 1)));
            end
            else
                send_item(rand_item());
        end
    endtask

    // Let the stream drain and the pipeline empty before touching registers.
    task automatic wait_idle();
        @(negedge clk);
        det_in_bus.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all eight registers in consecutive cycles.
    task automatic program_regs(cfg_t s);
        cfg_index_t            r;
        logic [CFG_DATA_W-1:0] v;
        for (int i = 0; i < 8; i++)
        begin
            r = cfg_index_t'(i);
            case (r)
                REG_SCORE_THRESHOLD: v = CFG_DATA_W'(s.score_threshold);
                REG_PAD_X:           v = CFG_DATA_W'(s.pad_x);
                REG_PAD_Y:           v = CFG_DATA_W'(s.pad_y);
                REG_SCALE_X:         v = CFG_DATA_W'(s.scale_x);
                REG_SCALE_Y:         v = CFG_DATA_W'(s.scale_y);
                REG_IMAGE_WIDTH:     v = CFG_DATA_W'(s.image_width);
                REG_IMAGE_HEIGHT:    v = CFG_DATA_W'(s.image_height);
                default:             v = CFG_DATA_W'(s.num_classes);
            endcase
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_data  <= v;
            sb.write_reg(r, v);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Output side: random stall before each result, one long hold on request.
    initial
    begin
        int   stall;
        res_t got;
        det_out_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = idle_on ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                det_out_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            det_out_bus.ready <= 1'b1;
            do @(posedge clk); while (!det_out_bus.valid);
            got.class_id   = det_out_bus.class_id;
            got.confidence = det_out_bus.confidence;
            got.left       = det_out_bus.left;
            got.top        = det_out_bus.top;
            got.width      = det_out_bus.width;
            got.height     = det_out_bus.height;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    // Watchdog: too long without a transfer on either stream ends the run.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_IDLE)
        begin
            @(posedge clk);
            if ((det_in_bus.valid && det_in_bus.ready) ||
                (det_out_bus.valid && det_out_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence: reset, directed checks, then random phases.
    initial
    begin
        det_item_t it;
        sb         = new();
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        det_in_bus.valid       = 1'b0;
        det_in_bus.kind        = KIND_BOX;
        det_in_bus.center_x    = '0;
        det_in_bus.center_y    = '0;
        det_in_bus.box_w       = '0;
        det_in_bus.box_h       = '0;
        det_in_bus.class_score = '0;
        det_in_bus.last_score  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values. Scores before any box use the empty held box.
        send_score(16'hFFFF, 1'b1);
        // A last flag on a box item does nothing.
        it            = rand_item();
        it.kind       = KIND_BOX;
        it.center_x   = 16'h1400;
        it.center_y   = 16'h1400;
        it.box_w      = 16'h0640;
        it.box_h      = 16'h0320;
        it.last_score = 1'b1;
        send_item(it);
        // A tie keeps the earlier class.
        send_score(16'h1000, 1'b0);
        send_score(16'h8000, 1'b0);
        send_score(16'h8000, 1'b0);
        send_score(16'h3000, 1'b1);
        // The argmax carries on past a last score and may report again.
        send_score(16'h9000, 1'b1);
        // Box hanging off the top left corner, score exactly at threshold.
        send_box(16'h0000, 16'h0000, 16'h0100, 16'h0100);
        send_score(16'h4000, 1'b1);
        // Just under the threshold.
        send_box(16'h1400, 16'h1400, 16'h0640, 16'h0320);
        send_score(16'h3FFF, 1'b1);
        // All fields at maximum: left lands past the image edge.
        send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_score(16'hFFFF, 1'b1);
        // Only zero scores: the best stays zero.
        send_box(16'h1400, 16'h1400, 16'h0640, 16'h0320);
        send_score(16'h0000, 1'b1);

        // No classes counted and a zero threshold: class zero, confidence zero.
        wait_idle();
        program_regs('{16'd0, 12'd0, 12'd0, 24'd65536, 24'd65536,
                       13'd640, 13'd640, 9'd0});
        send_box(16'h1400, 16'h1400, 16'h0640, 16'h0320);
        send_score(16'hFFFF, 1'b0);
        send_score(16'h1234, 1'b1);

        // Largest pads and scales; scores past the class count are ignored.
        wait_idle();
        program_regs('{16'h0100, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF,
                       13'h1FFF, 13'h1FFF, 9'd2});
        send_box(16'hFFFF, 16'hFFFF, 16'h0010, 16'h0010);
        send_score(16'h0200, 1'b0);
        send_score(16'h0300, 1'b0);
        send_score(16'h0400, 1'b1);

        // Zero image size and zero scale never report.
        wait_idle();
        program_regs('{16'd0, 12'd0, 12'd0, 24'd0, 24'd0, 13'd0, 13'd0, 9'd80});
        send_box(16'h1400, 16'h1400, 16'h0640, 16'h0320);
        send_score(16'hFFFF, 1'b1);

        // Typical settings.
        wait_idle();
        program_regs('{16'd16384, 12'd0, 12'd0, 24'd65536, 24'd65536,
                       13'd640, 13'd640, 9'd80});
        run_random(120);

        // Upper extremes, with one detection long enough to saturate the index.
        wait_idle();
        program_regs('{16'hFFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF,
                       13'h1FFF, 13'h1FFF, 9'h1FF});
        send_detection(520, 1'b1);
        run_random(60);

        // Lower extremes, no idling on either side.
        wait_idle();
        idle_on = 1'b0;
        program_regs('{16'd0, 12'd0, 12'd0, 24'h100000, 24'h100000,
                       13'd1, 13'd1, 9'd1});
        run_random(100);

        // Back-pressure: the output holds off while input keeps flowing.
        wait_idle();
        program_regs('{16'h0100, 12'd0, 12'd0, 24'd65536, 24'd65536,
                       13'h1FFF, 13'h1FFF, 9'd8});
        hold_req = 1'b1;
        run_random(180);

        // Random settings.
        for (int p = 0; p < 2; p++)
        begin
            wait_idle();
            idle_on = (p == 0);
            program_regs('{SCORE_W'($urandom_range(0, 16'hC000)),
                           PAD_W'($urandom_range(0, 64)),
                           PAD_W'($urandom_range(0, 64)),
                           SCALE_W'($urandom_range(24'h008000, 24'h040000)),
                           SCALE_W'($urandom_range(24'h008000, 24'h040000)),
                           PIX_W'($urandom_range(1, 8191)),
                           PIX_W'($urandom_range(1, 8191)),
                           NCLS_W'($urandom_range(1, 300))});
            run_random(100);
        end

        // Typical settings again until enough stimulus.
        wait_idle();
        idle_on = 1'b1;
        program_regs('{16'd16384, 12'd0, 12'd0, 24'd65536, 24'd65536,
                       13'd640, 13'd640, 9'd80});
        while (items_sent < ITEM_TARGET)
            run_random(50);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
